// File: hdl/u2a_pkg.sv
// Shared types, constants and the digit glyph function for the radix-to-ASCII converter.
package u2a_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_DIGITS_DEF = 64;
    localparam int VALUE_W        = 64;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int COUNT_W        = 32;
    localparam int DIV_STEP       = 8;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [PADDR_W-1:0] ADDR_RADIX  = 3'd0;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_LOAD
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d7;
        d7 = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
            return 7'd48 + d7;
        else
            return 7'd87 + d7;
    endfunction

endpackage

// File: hdl/unsigned_radix_to_ascii.sv
// Top level of the unsigned radix-to-ASCII converter: config port, digit store, front and back.
// Throughput: each value is divided digit by digit in the front's shared 8-step restoring divider;
//   no new value is accepted until its last digit is stored and the descriptor queue is not full.
// Output: a queued number's characters leave one per cycle while the receiver is ready.
// The front and back overlap through a two-bank digit store and a two-entry descriptor queue.
// Reset: radix returns to 10, the character count to zero; the digit store is not cleared.
module unsigned_radix_to_ascii import u2a_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [63:0] value
    // Result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] digit_char, [38:7] chars_so_far, [39] zero
    output logic                   m_tlast    // is_last
);

    localparam int POS_W = $clog2(MAX_DIGITS);
    // Two banks, one being filled and one being drained, each sized to the index width.
    localparam int STORE_DEPTH = 2 ** (POS_W + 1);

    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic                 cfg_write;

    logic                 ram_we;
    logic [POS_W:0]       ram_waddr;
    logic [DIGIT_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [POS_W:0]       ram_raddr;
    logic [DIGIT_W-1:0]   ram_rdata;

    queue_status_t        q_status;
    logic                 q_push;
    logic                 q_pop;
    logic [POS_W:0]       q_wdata;
    logic [POS_W:0]       q_rdata;

    logic [CHAR_W-1:0]    out_char;
    logic [COUNT_W-1:0]   out_count;

    // Configuration: one register, radix, at byte address zero. Writes elsewhere drop.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_RADIX);

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_write)
            radix_next = pwdata[RADIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Read back the radix; other addresses read as zero.
    assign prdata = (paddr == ADDR_RADIX) ? PDATA_W'(radix_reg) : '0;

    // Front: accept a value, divide it by the radix digit by digit into the store.
    u2a_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata),
        .radix     (radix_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // Digit store, banked by the high address bit.
    u2a_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Finished numbers wait here as {bank, index of most significant digit}.
    u2a_queue #(
        .WIDTH (POS_W + 1)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    // Back: walk each stored number from its top digit down and emit characters.
    u2a_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_char    (out_char),
        .m_last    (m_tlast),
        .m_count   (out_count)
    );

    assign m_tdata = {1'b0, out_count, out_char};

endmodule

// File: hdl/u2a_ram.sv
// Generic single-write, single-read RAM with registered read data.
module u2a_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/u2a_queue.sv
// Two-entry descriptor queue between the digit generator and the character emitter.
module u2a_queue import u2a_pkg::*; #(
    parameter int WIDTH = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output queue_status_t    status
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = slot_reg[rd_ptr_reg];
    assign status.full  = cnt_reg[1];
    assign status.empty = (cnt_reg == 2'd0);

endmodule

// File: hdl/u2a_front.sv
// Front part: accept values and divide them into digits, least significant first.
module u2a_front import u2a_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [VALUE_W-1:0]                s_value,
    input  logic [RADIX_W-1:0]                radix,
    output logic                              ram_we,
    output logic [$clog2(MAX_DIGITS):0]       ram_waddr,
    output logic [DIGIT_W-1:0]                ram_wdata,
    input  queue_status_t                     q_status,
    output logic                              q_push,
    output logic [$clog2(MAX_DIGITS):0]       q_wdata
);

    localparam int POS_W   = $clog2(MAX_DIGITS);
    localparam int DIV_CYC = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W   = DIV_CYC * DIV_STEP;
    localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    front_state_t        state_reg, state_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [CYC_W-1:0]    cyc_reg, cyc_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic [RADIX_W-1:0]  base_reg, base_next;
    logic                bank_reg, bank_next;

    logic                accept;
    logic                last_cyc;
    logic                done;
    logic [DIV_W-1:0]    step_quo;
    logic [DIGIT_W-1:0]  step_rem;
    logic [RADIX_W-1:0]  eff_radix;

    // Clamp the configured radix to 2..16.
    always_comb
    begin
        if (radix < RADIX_MIN)
            eff_radix = RADIX_MIN;
        else if (radix > RADIX_MAX)
            eff_radix = RADIX_MAX;
        else
            eff_radix = radix;
    end

    // Eight restoring-division steps per cycle on a narrow remainder.
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        logic [DIV_W-1:0]   q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {r, q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (t >= base_reg)
            begin
                t    = t - base_reg;
                q[0] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        step_quo = q;
        step_rem = r;
    end

    assign s_tready = (state_reg == F_IDLE) && !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign last_cyc = (cyc_reg == CYC_W'(DIV_CYC - 1));
    assign done     = (step_quo == '0) || (idx_reg == POS_W'(MAX_DIGITS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                if (last_cyc && done)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cyc_next  = cyc_reg;
        idx_next  = idx_reg;
        base_next = base_reg;
        bank_next = bank_reg;
        ram_we    = 1'b0;
        q_push    = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    quo_next  = DIV_W'(s_value[VALUE_BITS-1:0]);
                    rem_next  = '0;
                    cyc_next  = '0;
                    idx_next  = '0;
                    base_next = eff_radix;
                end
            end
            F_DIV:
            begin
                quo_next = step_quo;
                if (last_cyc)
                begin
                    ram_we   = 1'b1;
                    rem_next = '0;
                    cyc_next = '0;
                    if (done)
                    begin
                        q_push    = 1'b1;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    rem_next = step_rem;
                    cyc_next = cyc_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ram_waddr = {bank_reg, idx_reg};
    assign ram_wdata = step_rem;
    assign q_wdata   = {bank_reg, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cyc_reg  <= cyc_next;
        idx_reg  <= idx_next;
        base_reg <= base_next;
    end

endmodule

// File: hdl/u2a_back.sv
// Back part: read stored digits most significant first and emit them as characters.
module u2a_back import u2a_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  queue_status_t                 q_status,
    input  logic [$clog2(MAX_DIGITS):0]   q_rdata,
    output logic                          q_pop,
    output logic                          ram_re,
    output logic [$clog2(MAX_DIGITS):0]   ram_raddr,
    input  logic [DIGIT_W-1:0]            ram_rdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [CHAR_W-1:0]             m_char,
    output logic                          m_last,
    output logic [COUNT_W-1:0]            m_count
);

    localparam int POS_W = $clog2(MAX_DIGITS);

    back_state_t         state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                bank_reg, bank_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic                slot_free;
    logic                load;

    assign slot_free = !valid_reg || m_tready;
    assign load      = (state_reg == B_LOAD) && slot_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                    state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (load && (pos_reg == '0))
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        pos_next   = pos_reg;
        bank_next  = bank_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        count_next = count_reg;
        ram_re     = 1'b0;
        ram_raddr  = {bank_reg, pos_reg - 1'b1};
        q_pop      = 1'b0;
        if (valid_reg && m_tready)
            valid_next = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = q_rdata;
                    bank_next = q_rdata[POS_W];
                    pos_next  = q_rdata[POS_W-1:0];
                end
            end
            B_LOAD:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    char_next  = glyph(ram_rdata);
                    last_next  = (pos_reg == '0);
                    count_next = count_reg + 1'b1;
                    if (pos_reg == '0)
                    begin
                        q_pop = 1'b1;
                    end
                    else
                    begin
                        // Fetch the next lower digit while this one goes out.
                        ram_re   = 1'b1;
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        bank_reg <= bank_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_char   = char_reg;
    assign m_last   = last_reg;
    assign m_count  = count_reg;

endmodule

// File: tb/unsigned_radix_to_ascii_checker.sv
// Checker for the radix-to-ASCII converter: predicts each digit character and compares results.
`timescale 1ns / 100ps

module unsigned_radix_to_ascii_checker import u2a_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [63:0] value
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] digit_char, [38:7] chars_so_far, [39] zero
    input  logic                   m_tlast,   // is_last
    output int                     mismatch_count,
    output int                     chars_pending
);

    localparam logic [8*16-1:0] GLYPH_ROM = "0123456789abcdef";

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } char_rec_t;

    char_rec_t          pending_chars[$];
    logic [RADIX_W-1:0] radix_copy;
    logic [COUNT_W-1:0] char_total;

    // Expand one value into its digit characters, most significant first.
    task automatic expand_digits(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] n;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] rem;
        logic [3:0]         digs[64];
        int                 len;
        char_rec_t          rec;
        if (radix_copy < RADIX_MIN)
            base = VALUE_W'(RADIX_MIN);
        else if (radix_copy > RADIX_MAX)
            base = VALUE_W'(RADIX_MAX);
        else
            base = VALUE_W'(radix_copy);
        n = v;
        len = 0;
        do
        begin
            rem = n % base;
            digs[len] = rem[3:0];
            n = n / base;
            len++;
        end
        while (n != 0 && len < MAX_DIGITS_DEF);
        for (int k = len - 1; k >= 0; k--)
        begin
            char_total = char_total + 1;
            rec.ch = GLYPH_ROM[8*(15 - digs[k]) +: CHAR_W];
            rec.last = (k == 0);
            rec.count = char_total;
            pending_chars.push_back(rec);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_rec_t want;
        if (!rst_n)
        begin
            radix_copy = RADIX_RESET;
            char_total = '0;
            pending_chars.delete();
            mismatch_count = 0;
            chars_pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RADIX)
                radix_copy = pwdata[RADIX_W-1:0];

            if (m_tvalid && m_tready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected character, expected none, got char %0d last %0b count %0d",
                             $time, m_tdata[6:0], m_tlast, m_tdata[38:7]);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (m_tdata[6:0] !== want.ch)
                    begin
                        $display("%0t: digit_char expected %0d, got %0d",
                                 $time, want.ch, m_tdata[6:0]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: is_last expected %0b, got %0b", $time, want.last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tdata[38:7] !== want.count)
                    begin
                        $display("%0t: chars_so_far expected %0d, got %0d",
                                 $time, want.count, m_tdata[38:7]);
                        mismatch_count++;
                    end
                    if (m_tdata[39] !== 1'b0)
                    begin
                        $display("%0t: tdata pad bit expected 0, got %b", $time, m_tdata[39]);
                        mismatch_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                expand_digits(s_tdata);

            chars_pending = pending_chars.size();
        end
    end

endmodule

// File: tb/unsigned_radix_to_ascii_tb.sv
// Testbench top for the radix-to-ASCII converter: clock, reset, stimulus and final verdict.
`timescale 1ns / 100ps

module unsigned_radix_to_ascii_tb;
    import u2a_pkg::*;

    // Byte address of a register slot that does not exist; writes there must be ignored.
    localparam logic [PADDR_W-1:0] ADDR_SPARE = 3'd4;
    // Settle time after the last character before touching the radix or ending the run.
    localparam int DRAIN_CYCLES = 16;
    // Worst case is 184 values of 64 digits, each character held off by a long stall.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_PER_PHASE = 9;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata;   // [63:0] value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [6:0] digit_char, [38:7] chars_so_far, [39] zero
    logic                   m_tlast;   // is_last

    int                     mismatch_count;
    int                     chars_pending;
    int                     cycle_count;
    logic                   steady;      // when set, the sender never idles
    logic [RADIX_W-1:0]     radix_now;   // radix as last written, for shaping values

    unsigned_radix_to_ascii dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    unsigned_radix_to_ascii_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost character ends here.
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** unsigned_radix_to_ascii: FAILED **");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Random value shaped to cover short, long and boundary digit strings in the current radix.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] base;
        int                 sel;
        int                 steps;
        sel = $urandom_range(0, 9);
        if (radix_now < RADIX_MIN)
            base = VALUE_W'(RADIX_MIN);
        else if (radix_now > RADIX_MAX)
            base = VALUE_W'(RADIX_MAX);
        else
            base = VALUE_W'(radix_now);
        case (sel)
            0: return VALUE_W'($urandom_range(0, 20));
            1: return {$urandom, $urandom} | {VALUE_W{1'b1}} >> $urandom_range(0, 3);
            2, 3:
            begin
                // Land on a power of the radix or one below it, where the digit count steps.
                p = 1;
                steps = $urandom_range(1, 64);
                repeat (steps)
                    if (p <= {VALUE_W{1'b1}} / base)
                        p = p * base;
                return p - VALUE_W'($urandom_range(0, 1));
            end
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Offer one value and hold it until accepted; leave valid high for a back-to-back follower.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = v;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Two-phase register write: setup, then access until the slave is ready.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drop valid, then wait until every predicted character is out and the block has gone quiet.
    task automatic drain_block();
        s_tvalid = 1'b0;
        while (chars_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Receiver: ready runs of random length broken by stalls of random length.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            int run;
            int gap;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            m_tready = 1'b1;
            repeat (run) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        int radix_plan[$];
        int phase;
        radix_plan = '{2, 16, 0, 1, 17, 31, 3, 5, 7, 8, 9, 11, 12, 13, 14, 15, 10, 6};

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        steady = 1'b0;
        radix_now = RADIX_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset radix: zero, single digits, the carry into a new digit, and full-width values.
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'hFFFF_FFFF);
        send_value(64'h1_0000_0000);
        send_value(64'd9999999999999999999);
        send_value(64'd10000000000000000000);
        send_value(64'h8000_0000_0000_0000);
        send_value({VALUE_W{1'b1}});
        drain_block();

        for (phase = 0; phase < radix_plan.size(); phase++)
        begin
            radix_now = RADIX_W'(radix_plan[phase]);
            // Upper data bits are don't-care for the radix; keep them random.
            write_reg(ADDR_RADIX, {(PDATA_W-RADIX_W)'($urandom), radix_now});
            // Writes to a nonexistent register must leave the radix alone.
            if ($urandom_range(0, 1) == 1)
                write_reg(ADDR_SPARE, $urandom);
            steady = (phase % 4 == 3);

            case (radix_plan[phase])
                2:
                begin
                    send_value(64'd0);
                    send_value(64'd1);
                    send_value({VALUE_W{1'b1}});
                    send_value(64'h8000_0000_0000_0000);
                end
                16:
                begin
                    send_value(64'hF);
                    send_value(64'h10);
                    send_value(64'h0123_4567_89AB_CDEF);
                    send_value(64'hFEDC_BA98_7654_3210);
                end
                // A radix below two acts as binary, one above sixteen as hex.
                0: send_value(64'd5);
                31: send_value(64'hFF);
                default: ;
            endcase

            repeat (RANDOM_PER_PHASE)
                send_value(pick_value());
            drain_block();
        end

        if (mismatch_count == 0)
            $display("** unsigned_radix_to_ascii: PASSED **");
        else
            $display("** unsigned_radix_to_ascii: FAILED **");
        $finish;
    end

endmodule
